// ----- src/kcl_pkg.sv -----
// Shared types, codes and constants for the keypad code lock.
// Used by every module of the lock and by its port checker.
// No dependencies.
package kcl_pkg;

   localparam int CODE_DIGITS = 4;
   localparam int CNT_W = $clog2(CODE_DIGITS + 1);
   localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_FAILURES  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_LOCKOUT_TICKS = 3'd4;

   localparam logic [3:0]  MAX_FAILURES_RESET  = 4'd3;
   localparam logic [15:0] LOCKOUT_TICKS_RESET = 16'd10;
   localparam logic [3:0]  FAILURES_MAX        = 4'd15;

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
   localparam logic [3:0] KEY_STAR       = 4'd10;
   localparam logic [3:0] KEY_HASH       = 4'd11;
   localparam logic [3:0] KEY_D          = 4'd15;

   typedef enum logic [3:0] {
      ST_NONE         = 4'd0,
      ST_DIGIT        = 4'd1,
      ST_GRANTED      = 4'd2,
      ST_WRONG        = 4'd3,
      ST_LOCKOUT      = 4'd4,
      ST_ASK_OLD      = 4'd5,
      ST_ASK_NEW      = 4'd6,
      ST_WRONG_OLD    = 4'd7,
      ST_TOO_FEW      = 4'd8,
      ST_UPDATED      = 4'd9,
      ST_CLEARED      = 4'd10,
      ST_LOCKED_IGNORE = 4'd11,
      ST_UNLOCKED     = 4'd12
   } status_type;

   typedef enum logic [1:0] {
      BEEP_NONE  = 2'd0,
      BEEP_SHORT = 2'd1,
      BEEP_LONG  = 2'd2
   } beep_type;

   typedef enum logic [1:0] {
      MODE_ACCESS = 2'd0,
      MODE_OLD    = 2'd1,
      MODE_NEW    = 2'd2
   } mode_type;

   typedef struct packed {
      logic [3:0]  max_failures;
      logic [15:0] lockout_ticks;
   } cfg_type;

   typedef struct packed {
      status_type status;
      beep_type   beep;
      logic       is_locked;
      logic [1:0] entry_mode;
      logic [2:0] digits_entered;
      logic [3:0] failures;
   } result_type;

   // Factory code 2005; any further digits are zero.
   function automatic logic [3:0] default_digit(input int pos);
      logic [3:0] d;
      case (pos)
         0:       d = 4'd2;
         3:       d = 4'd5;
         default: d = 4'd0;
      endcase
      return d;
   endfunction

endpackage

// ----- src/kcl_csr.sv -----
// Configuration registers of the keypad code lock behind an APB-style port.
// Depends on kcl_pkg.
module kcl_csr
   import kcl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic    wr_en;
   cfg_type cfg_ff;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_failures  <= MAX_FAILURES_RESET;
         cfg_ff.lockout_ticks <= LOCKOUT_TICKS_RESET;
      end else if (wr_en) begin
         unique case (csr_paddr)
            ADDR_MAX_FAILURES:  cfg_ff.max_failures  <= csr_pwdata[3:0];
            ADDR_LOCKOUT_TICKS: cfg_ff.lockout_ticks <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         ADDR_MAX_FAILURES:  csr_prdata = {{(CSR_DATA_W-4){1'b0}}, cfg_ff.max_failures};
         ADDR_LOCKOUT_TICKS: csr_prdata = {{(CSR_DATA_W-16){1'b0}}, cfg_ff.lockout_ticks};
         default:            csr_prdata = '0;
      endcase
   end

endmodule

// ----- src/kcl_ctrl.sv -----
// Lock state (codes, entry buffer, mode, failures, lockout timer) and the
// combinational update that turns one item into one result. Depends on kcl_pkg.
module kcl_ctrl
   import kcl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic       op,
   input  logic [3:0] key_code,
   input  cfg_type    cfg,
   output result_type result
);

   logic [3:0]       saved_code_ff   [CODE_DIGITS];
   logic [3:0]       entry_digits_ff [CODE_DIGITS];
   logic [CNT_W-1:0] entry_count_ff, entry_count_in;
   mode_type         mode_ff, mode_in;
   logic [3:0]       failures_ff, failures_in;
   logic             lock_ff, lock_in;
   logic [15:0]      timer_ff, timer_in;
   logic             digit_wr;
   logic             code_wr;
   logic             code_hit;
   logic [3:0]       fail_inc;

   always_comb begin
      code_hit = (entry_count_ff == CNT_W'(CODE_DIGITS));
      for (int i = 0; i < CODE_DIGITS; i++) begin
         if (entry_digits_ff[i] != saved_code_ff[i]) code_hit = 1'b0;
      end
   end

   assign fail_inc = (failures_ff != FAILURES_MAX) ? failures_ff + 4'd1 : failures_ff;

   always_comb begin
      entry_count_in = entry_count_ff;
      mode_in        = mode_ff;
      failures_in    = failures_ff;
      lock_in        = lock_ff;
      timer_in       = timer_ff;
      digit_wr       = 1'b0;
      code_wr        = 1'b0;
      result.status  = ST_NONE;
      result.beep    = BEEP_NONE;

      if (op == OP_TICK) begin
         if (lock_ff) begin
            if (timer_ff <= 16'd1) begin
               timer_in      = '0;
               lock_in       = 1'b0;
               failures_in   = '0;
               result.status = ST_UNLOCKED;
            end else begin
               timer_in = timer_ff - 16'd1;
            end
         end
      end else if (lock_ff) begin
         result.status = ST_LOCKED_IGNORE;
      end else if (key_code == KEY_D && mode_ff == MODE_ACCESS) begin
         mode_in        = MODE_OLD;
         entry_count_in = '0;
         result.status  = ST_ASK_OLD;
      end else if (key_code <= KEY_LAST_DIGIT) begin
         if (entry_count_ff < CNT_W'(CODE_DIGITS)) begin
            digit_wr       = 1'b1;
            entry_count_in = entry_count_ff + CNT_W'(1);
            result.status  = ST_DIGIT;
         end
      end else if (key_code == KEY_HASH) begin
         case (mode_ff)
            MODE_ACCESS: begin
               entry_count_in = '0;
               if (code_hit) begin
                  failures_in   = '0;
                  result.status = ST_GRANTED;
               end else begin
                  failures_in   = fail_inc;
                  result.beep   = BEEP_SHORT;
                  result.status = ST_WRONG;
                  if (fail_inc >= cfg.max_failures) begin
                     result.beep   = BEEP_LONG;
                     result.status = ST_LOCKOUT;
                     lock_in       = 1'b1;
                     timer_in      = cfg.lockout_ticks;
                  end
               end
            end
            MODE_OLD: begin
               entry_count_in = '0;
               if (code_hit) begin
                  mode_in       = MODE_NEW;
                  result.status = ST_ASK_NEW;
               end else begin
                  mode_in       = MODE_ACCESS;
                  result.status = ST_WRONG_OLD;
               end
            end
            default: begin
               if (entry_count_ff < CNT_W'(CODE_DIGITS)) begin
                  result.status = ST_TOO_FEW;
               end else begin
                  code_wr        = 1'b1;
                  mode_in        = MODE_ACCESS;
                  entry_count_in = '0;
                  result.status  = ST_UPDATED;
               end
            end
         endcase
      end else if (key_code == KEY_STAR) begin
         entry_count_in = '0;
         mode_in        = MODE_ACCESS;
         result.status  = ST_CLEARED;
      end

      result.is_locked      = lock_in;
      result.entry_mode     = mode_in;
      result.digits_entered = 3'(entry_count_in);
      result.failures       = failures_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         mode_ff        <= MODE_ACCESS;
         failures_ff    <= '0;
         lock_ff        <= 1'b0;
         timer_ff       <= '0;
         for (int i = 0; i < CODE_DIGITS; i++) begin
            saved_code_ff[i] <= default_digit(i);
         end
      end else if (fire) begin
         entry_count_ff <= entry_count_in;
         mode_ff        <= mode_in;
         failures_ff    <= failures_in;
         lock_ff        <= lock_in;
         timer_ff       <= timer_in;
         if (code_wr) begin
            saved_code_ff <= entry_digits_ff;
         end
      end
   end

   // Entry buffer has no reset; a compare or a save needs it full.
   always_ff @(posedge clock) begin
      if (fire && digit_wr) begin
         entry_digits_ff[entry_count_ff[IDX_W-1:0]] <= key_code;
      end
   end

endmodule

// ----- src/keypad_code_lock_with_lockout_core.sv -----
// Top level of the keypad code lock with lockout.
// Depends on kcl_pkg, kcl_csr and kcl_ctrl.
//
//   channel   ports                         transfer when
//   -------   ---------------------------   ---------------------------------
//   request   req_op, req_key_code           req_valid && req_ready
//   response  rsp_status .. rsp_failures     rsp_valid && rsp_ready
//   config    csr_psel .. csr_prdata         psel && penable && pwrite && pready
//
// One item per cycle sustained while responses are taken; each item is held
// in the input register, updates the lock state on its way into the result
// register and is shown on the response channel from that register.
// The loop through the lock state registers holds no other register.
// Reset is synchronous and restores code 2005, normal mode, no lockout,
// three failures allowed and ten ticks of lockout.
// A stalled response holds the item in the input register; new requests are
// taken as long as that register is empty or moving.
module keypad_code_lock_with_lockout_core
   import kcl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   input  logic [3:0]            req_key_code,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [3:0]            rsp_status,
   output logic [1:0]            rsp_beep,
   output logic                  rsp_is_locked,
   output logic [1:0]            rsp_entry_mode,
   output logic [2:0]            rsp_digits_entered,
   output logic [3:0]            rsp_failures,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   logic       in_valid_ff;
   logic       in_op_ff;
   logic [3:0] in_key_ff;
   logic       rsp_valid_ff;
   logic       advance;

   kcl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Advance the held item into the result register when that register
   // is empty or being drained this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register: hold the accepted key or tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff  <= req_op;
         in_key_ff <= req_key_code;
      end
   end

   // State update commits exactly when the item leaves the input register.
   kcl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .op       (in_op_ff),
      .key_code (in_key_ff),
      .cfg      (cfg),
      .result   (result)
   );

   // Result register: drop the valid once transferred, load on advance.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_beep           = rsp_ff.beep;
   assign rsp_is_locked      = rsp_ff.is_locked;
   assign rsp_entry_mode     = rsp_ff.entry_mode;
   assign rsp_digits_entered = rsp_ff.digits_entered;
   assign rsp_failures       = rsp_ff.failures;

endmodule

// ----- src/kcl_checker.sv -----
// Port-level checks for the keypad code lock, bound to the top level.
// Depends on kcl_pkg and keypad_code_lock_with_lockout_core.
module kcl_checker
   import kcl_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_status,
   input logic [1:0] rsp_beep,
   input logic       rsp_is_locked,
   input logic [1:0] rsp_entry_mode,
   input logic [2:0] rsp_digits_entered,
   input logic [3:0] rsp_failures
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_failures))
      else $error("response changed while stalled");

   a_lockout_locks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_LOCKOUT |-> rsp_is_locked && rsp_beep == BEEP_LONG)
      else $error("lockout result without lock or long beep");

   a_unlock_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_UNLOCKED |-> !rsp_is_locked && rsp_failures == 4'd0)
      else $error("unlock left lock or failures set");

   a_granted_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_GRANTED |->
         rsp_failures == 4'd0 && rsp_digits_entered == 3'd0 && rsp_entry_mode == MODE_ACCESS)
      else $error("grant left stale entry state");

   a_beep_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beep != BEEP_NONE |->
         rsp_status == ST_WRONG || rsp_status == ST_LOCKOUT)
      else $error("beep on a result that is not a miss");

endmodule

bind keypad_code_lock_with_lockout_core kcl_checker u_kcl_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_beep           (rsp_beep),
   .rsp_is_locked      (rsp_is_locked),
   .rsp_entry_mode     (rsp_entry_mode),
   .rsp_digits_entered (rsp_digits_entered),
   .rsp_failures       (rsp_failures)
);
